// File: rtl/clcc_pkg.sv
package clcc_pkg;

  // Input word commands
  typedef enum logic [1:0] {
    CMD_SENSOR = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_COOLER = 2'd2,
    CMD_LED    = 2'd3
  } cmd_e;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_MARGIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_THRESHOLD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_MARGIN     = 3'd4;
  localparam int unsigned CFG_DATA_W = 10;

  // Register reset values
  localparam logic [9:0]        LIGHT_THRESHOLD_RST = 10'd600;
  localparam logic [9:0]        LIGHT_MARGIN_RST    = 10'd100;
  localparam logic signed [7:0] TEMP_THRESHOLD_RST  = 8'sd23;
  localparam logic [6:0]        TEMP_MARGIN_RST     = 7'd7;

  // Duty regulation constants
  localparam logic [7:0] DUTY_STEP = 8'd5;
  localparam logic [7:0] DUTY_TOP  = 8'd250;
  localparam logic [7:0] DUTY_MAX  = 8'd255;

  typedef struct packed {
    logic [1:0]          command;
    logic [9:0]          light_sample;
    logic signed [11:0]  temperature;
    logic signed [15:0]  manual_value;
  } in_word_t;

  typedef struct packed {
    logic [7:0] led_duty;
    logic       cooler_on;
    logic [9:0] light_level;
  } out_word_t;

  typedef struct packed {
    logic               auto_mode;
    logic [9:0]         light_threshold;
    logic [9:0]         light_margin;
    logic signed [7:0]  temp_threshold;
    logic [6:0]         temp_margin;
  } cfg_t;

  // Classified operation handed from front to back
  typedef struct packed {
    cmd_e               cmd;
    logic [9:0]         sample;
    logic [9:0]         sample_quo;   // sample divided by the averaging count
    logic signed [11:0] temperature;
    logic [7:0]         duty;         // manual duty, already saturated
    logic               cooler_ok;    // manual cooler value is 0 or 1
    logic               cooler_val;
  } op_t;

endpackage

// File: rtl/clcc_front.sv
module clcc_front #(
  parameter int SAMPLES_PER_AVERAGE = 10
) (
  input  logic             in_valid,
  output logic             in_ready,
  input  clcc_pkg::in_word_t in_data,
  input  logic             q_full,
  output logic             q_push,
  output clcc_pkg::op_t    q_data
);
  import clcc_pkg::*;

  // Reciprocal of the averaging count, exact for 10-bit samples
  localparam int SH = 18;
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << SH) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE;
  localparam logic [SH:0] RECIP = RECIP_FULL[SH:0];

  logic [SH+10:0] quo_prod;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  assign quo_prod = {{SH{1'b0}}, 1'b0, in_data.light_sample} * {10'd0, RECIP};

  // Classify the word and precompute the per-command values
  always_comb begin
    q_data.cmd         = cmd_e'(in_data.command);
    q_data.sample      = in_data.light_sample;
    q_data.sample_quo  = quo_prod[SH+9:SH];
    q_data.temperature = in_data.temperature;
    if (in_data.manual_value < 16'sd0) begin
      q_data.duty = 8'd0;
    end else if (in_data.manual_value > 16'sd255) begin
      q_data.duty = DUTY_MAX;
    end else begin
      q_data.duty = in_data.manual_value[7:0];
    end
    q_data.cooler_ok  = (in_data.manual_value == 16'sd0) || (in_data.manual_value == 16'sd1);
    q_data.cooler_val = in_data.manual_value[0];
  end

endmodule

// File: rtl/clcc_fifo.sv
module clcc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/clcc_back.sv
module clcc_back #(
  parameter int SAMPLES_PER_AVERAGE = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  clcc_pkg::cfg_t     cfg,
  input  logic               op_valid,
  input  clcc_pkg::op_t      op_data,
  output logic               op_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output clcc_pkg::out_word_t out_data
);
  import clcc_pkg::*;

  localparam int CW = $clog2(SAMPLES_PER_AVERAGE + 1);
  localparam int RW = $clog2(SAMPLES_PER_AVERAGE) + 1;
  localparam int NW = $clog2(SAMPLES_PER_AVERAGE + 1);
  localparam logic [NW-1:0] NV   = NW'(SAMPLES_PER_AVERAGE);
  localparam logic [RW-1:0] NR   = RW'(SAMPLES_PER_AVERAGE);
  localparam logic [CW-1:0] LAST = CW'(SAMPLES_PER_AVERAGE - 1);

  // Running sum held as quotient and remainder by the averaging count
  logic [CW-1:0]      count_r, count_nxt;
  logic [9:0]         quo_r, quo_nxt;
  logic [RW-1:0]      rem_r, rem_nxt;
  logic [9:0]         avg_r, avg_nxt;
  logic signed [11:0] temp_r, temp_nxt;
  logic [7:0]         duty_r, duty_nxt;
  logic               cooler_r, cooler_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [9:0]          quo_mul;
  logic [RW-1:0]       rem_in;
  logic [RW-1:0]       rem_sum;
  logic                carry;
  logic [9:0]          quo_sum;
  logic signed [11:0]  lvl;
  logic signed [11:0]  light_lo;
  logic signed [11:0]  light_hi;
  logic signed [8:0]   temp_deg;
  logic signed [12:0]  temp_limit;

  assign op_pop    = op_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = '{led_duty: duty_r, cooler_on: cooler_r, light_level: avg_r};

  // Sample accumulation
  assign quo_mul = 10'(op_data.sample_quo * NV);
  assign rem_in  = RW'(op_data.sample - quo_mul);
  assign rem_sum = rem_r + rem_in;
  assign carry   = (rem_sum >= NR);
  assign quo_sum = quo_r + op_data.sample_quo + {9'd0, carry};

  // Deadband and cooler limits from configuration
  assign lvl        = $signed({2'b00, avg_r});
  assign light_lo   = $signed({2'b00, cfg.light_threshold}) - $signed({2'b00, cfg.light_margin});
  assign light_hi   = $signed({2'b00, cfg.light_threshold}) + $signed({2'b00, cfg.light_margin});
  assign temp_deg   = {cfg.temp_threshold[7], cfg.temp_threshold} + $signed({2'b00, cfg.temp_margin});
  // Limit in tenths: 8 * degrees plus 2 * degrees
  assign temp_limit = $signed({temp_deg[8], temp_deg, 3'b000})
                    + $signed({{3{temp_deg[8]}}, temp_deg, 1'b0});

  // Execute one operation
  always_comb begin
    count_nxt     = count_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    avg_nxt       = avg_r;
    temp_nxt      = temp_r;
    duty_nxt      = duty_r;
    cooler_nxt    = cooler_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (op_pop) begin
      out_valid_nxt = 1'b1;
      case (op_data.cmd)
        CMD_SENSOR: begin
          temp_nxt = op_data.temperature;
          if (count_r == LAST) begin
            avg_nxt   = quo_sum;
            quo_nxt   = '0;
            rem_nxt   = '0;
            count_nxt = '0;
          end else begin
            quo_nxt   = quo_sum;
            rem_nxt   = carry ? rem_sum - NR : rem_sum;
            count_nxt = count_r + 1'b1;
          end
        end
        CMD_TICK: begin
          if (cfg.auto_mode) begin
            if (lvl < light_lo && duty_r > DUTY_STEP) begin
              duty_nxt = duty_r - DUTY_STEP;
            end else if (lvl > light_hi && duty_r < DUTY_TOP) begin
              duty_nxt = duty_r + DUTY_STEP;
            end
            cooler_nxt = ($signed({temp_r[11], temp_r}) > temp_limit);
          end
        end
        CMD_COOLER: begin
          if (!cfg.auto_mode && op_data.cooler_ok) begin
            cooler_nxt = op_data.cooler_val;
          end
        end
        default: begin
          if (!cfg.auto_mode) begin
            duty_nxt = op_data.duty;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      quo_r       <= '0;
      rem_r       <= '0;
      avg_r       <= '0;
      temp_r      <= '0;
      duty_r      <= '0;
      cooler_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      quo_r       <= quo_nxt;
      rem_r       <= rem_nxt;
      avg_r       <= avg_nxt;
      temp_r      <= temp_nxt;
      duty_r      <= duty_nxt;
      cooler_r    <= cooler_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/climate_light_cooler_controller.sv
// An accepted word enters the queue; the executor pops it and registers its result word.
// Throughput: one word per cycle while out_ready stays high; the two-entry queue between
// classifier and executor lets the input keep flowing while a result waits, until it fills.
// Reset (rst_n low, synchronous): queue and result emptied, all state cleared,
// configuration registers return to manual mode, 600, 100, 23 and 7.
module climate_light_cooler_controller #(
  parameter int SAMPLES_PER_AVERAGE = 10
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  clcc_pkg::in_word_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output clcc_pkg::out_word_t                   out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [clcc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [clcc_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import clcc_pkg::*;

  cfg_t cfg_r;
  op_t  push_data;
  op_t  pop_data;
  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_valid;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.auto_mode       <= 1'b0;
      cfg_r.light_threshold <= LIGHT_THRESHOLD_RST;
      cfg_r.light_margin    <= LIGHT_MARGIN_RST;
      cfg_r.temp_threshold  <= TEMP_THRESHOLD_RST;
      cfg_r.temp_margin     <= TEMP_MARGIN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_AUTO_MODE:       cfg_r.auto_mode       <= cfg_data[0];
        CFG_LIGHT_THRESHOLD: cfg_r.light_threshold <= cfg_data[9:0];
        CFG_LIGHT_MARGIN:    cfg_r.light_margin    <= cfg_data[9:0];
        CFG_TEMP_THRESHOLD:  cfg_r.temp_threshold  <= $signed(cfg_data[7:0]);
        CFG_TEMP_MARGIN:     cfg_r.temp_margin     <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Front: accept and classify
  clcc_front #(
    .SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE)
  ) u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (push_data)
  );

  // Queue between front and back
  clcc_fifo #(
    .WIDTH($bits(op_t)),
    .DEPTH(2)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (pop_data)
  );

  // Back: execute and hold results
  clcc_back #(
    .SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .op_valid  (q_valid),
    .op_data   (pop_data),
    .op_pop    (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
